// ===== src/telemetry_line_parser_top_defines.svh =====
// Assertion macros for the telemetry line parser.
`ifndef TELEMETRY_LINE_PARSER_TOP_DEFINES_SVH
`define TELEMETRY_LINE_PARSER_TOP_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define TLP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk_i and rst_ni.
`define TLP_ASSERT(label, prop, msg) \
  `TLP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/tlp_pkg.sv =====
// Types and constants for the telemetry line parser.
package tlp_pkg;

  localparam int unsigned VALUE_W    = 14;
  localparam int unsigned NUM_VALUES = 6;
  localparam int unsigned TOKEN_W    = 3;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [TOKEN_W-1:0] NUM_TOKENS = 3'd7;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;

  localparam logic [CHAR_W-1:0] CHAR_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_V     = 8'h56;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;

  typedef logic [NUM_VALUES-1:0][VALUE_W-1:0] values_t;

  typedef struct packed {
    logic [CHAR_W-1:0] mode_char;
    values_t           values;
  } result_t;

endpackage

// ===== src/telemetry_line_parser_top.sv =====
// Telemetry line parser: byte-at-a-time line tokenizer with result buffering.
//
// Takes one received byte per cycle while in_stall_o is low. A 'C', 'V' or '+'
// starts a line; commas split it into tokens, token 0 gives the mode character
// and tokens 1 to 6 give decimal values (leading digits of at most
// FIELD_CHARS-1 kept characters, saturating at 9999). A newline that ends an
// open line commits the fields present in it and produces one result, which
// waits in the skid register while the output register holds an untaken one;
// fields a line lacks keep earlier values. Lines longer than LINE_CHARS characters
// are dropped silently. The parse state is registered from each taken byte and
// the current state; the result path is an output register backed by a skid
// register, so in_stall_o rises only while both hold results not yet taken.
module telemetry_line_parser_top #(
  parameter int unsigned LINE_CHARS  = 32,
  parameter int unsigned FIELD_CHARS = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlp_pkg::CHAR_W-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlp_pkg::CHAR_W-1:0]   mode_char_o,
  output logic [tlp_pkg::VALUE_W-1:0]  steam_temp_o,
  output logic [tlp_pkg::VALUE_W-1:0]  target_temp_o,
  output logic [tlp_pkg::VALUE_W-1:0]  exchanger_temp_o,
  output logic [tlp_pkg::VALUE_W-1:0]  boost_countdown_o,
  output logic [tlp_pkg::VALUE_W-1:0]  heater_on_o,
  output logic [tlp_pkg::VALUE_W-1:0]  pump_on_o
);
  import tlp_pkg::*;

  `include "telemetry_line_parser_top_defines.svh"

  localparam int unsigned CNT_W  = $clog2(LINE_CHARS + 1);
  localparam int unsigned LEN_W  = $clog2(FIELD_CHARS);
  localparam int unsigned PROD_W = VALUE_W + 4;
  localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(LINE_CHARS);
  localparam logic [LEN_W-1:0] KEEP_MAX = LEN_W'(FIELD_CHARS - 1);

  // parse state
  logic               in_line_q, in_line_d;
  logic [CNT_W-1:0]   char_count_q, char_count_d;
  logic [TOKEN_W-1:0] token_number_q, token_number_d;
  logic               token_open_q, token_open_d;
  logic [LEN_W-1:0]   token_length_q, token_length_d;
  logic               digits_ended_q, digits_ended_d;
  logic               text_ended_q, text_ended_d;
  logic [CHAR_W-1:0]  line_mode_q, line_mode_d;
  values_t            line_values_q, line_values_d;
  logic [CHAR_W-1:0]  mode_value_q, mode_value_d;
  values_t            field_values_q, field_values_d;

  // result buffering
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, result;

  logic               in_acc, out_take, emit, new_res;
  logic [CHAR_W-1:0]  c;
  logic [TOKEN_W-1:0] val_idx;
  logic [VALUE_W-1:0] cur_val;
  logic [PROD_W-1:0]  prod;

  assign c        = rx_byte_i;
  assign in_stall_o = skid_valid_q;
  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;
  assign new_res  = in_acc && emit;

  always_comb begin
    in_line_d      = in_line_q;
    char_count_d   = char_count_q;
    token_number_d = token_number_q;
    token_open_d   = token_open_q;
    token_length_d = token_length_q;
    digits_ended_d = digits_ended_q;
    text_ended_d   = text_ended_q;
    line_mode_d    = line_mode_q;
    line_values_d  = line_values_q;
    mode_value_d   = mode_value_q;
    field_values_d = field_values_q;
    emit           = 1'b0;
    val_idx        = token_number_q - 3'd1;
    cur_val        = '0;
    prod           = '0;

    // a start character restarts the line even mid-line
    if (c == CHAR_C || c == CHAR_V || c == CHAR_PLUS) begin
      in_line_d      = 1'b1;
      char_count_d   = '0;
      token_number_d = '0;
      token_open_d   = 1'b0;
      token_length_d = '0;
      digits_ended_d = 1'b0;
      text_ended_d   = 1'b0;
      line_mode_d    = '0;
      line_values_d  = '0;
    end

    val_idx = token_number_d - 3'd1;
    cur_val = line_values_d[val_idx];
    prod    = (PROD_W'(cur_val) << 3) + (PROD_W'(cur_val) << 1)
              + PROD_W'(c - CHAR_0);

    if (in_line_d) begin
      if (c != CHAR_NL) begin
        if (char_count_d < LINE_MAX) begin
          char_count_d = char_count_d + 1'b1;
          if (!text_ended_d) begin
            if (c == CHAR_NUL) begin
              text_ended_d = 1'b1;
            end else if (c == CHAR_COMMA) begin
              if (token_open_d) begin
                token_open_d = 1'b0;
                if (token_number_d < NUM_TOKENS) begin
                  token_number_d = token_number_d + 1'b1;
                end
              end
            end else begin
              if (!token_open_d) begin
                token_open_d   = 1'b1;
                token_length_d = '0;
                digits_ended_d = 1'b0;
              end
              if (token_length_d < KEEP_MAX) begin
                if (token_number_d == '0) begin
                  if (token_length_d == '0) begin
                    line_mode_d = c;
                  end
                end else if (token_number_d < NUM_TOKENS && !digits_ended_d) begin
                  if (c >= CHAR_0 && c <= CHAR_9) begin
                    line_values_d[val_idx] = (prod > PROD_W'(VALUE_MAX)) ?
                                             VALUE_MAX : prod[VALUE_W-1:0];
                  end else begin
                    digits_ended_d = 1'b1;
                  end
                end
                token_length_d = token_length_d + 1'b1;
              end
            end
          end
        end else begin
          // overlong line: dropped, this byte ignored
          in_line_d      = 1'b0;
          char_count_d   = '0;
          token_number_d = '0;
          token_open_d   = 1'b0;
          token_length_d = '0;
          digits_ended_d = 1'b0;
          text_ended_d   = 1'b0;
          line_mode_d    = '0;
          line_values_d  = '0;
        end
      end else begin
        // newline: commit tokens that the line holds
        if (token_number_d != '0 || token_open_d) begin
          mode_value_d = line_mode_d;
        end
        for (int i = 0; i < NUM_VALUES; i++) begin
          if (TOKEN_W'(i + 1) < token_number_d ||
              (token_open_d && TOKEN_W'(i + 1) == token_number_d)) begin
            field_values_d[i] = line_values_d[i];
          end
        end
        emit           = 1'b1;
        in_line_d      = 1'b0;
        char_count_d   = '0;
        token_number_d = '0;
        token_open_d   = 1'b0;
        token_length_d = '0;
        digits_ended_d = 1'b0;
        text_ended_d   = 1'b0;
        line_mode_d    = '0;
        line_values_d  = '0;
      end
    end
  end

  assign result.mode_char = mode_value_d;
  assign result.values    = field_values_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_line_q      <= 1'b0;
      char_count_q   <= '0;
      token_number_q <= '0;
      token_open_q   <= 1'b0;
      token_length_q <= '0;
      digits_ended_q <= 1'b0;
      text_ended_q   <= 1'b0;
      line_mode_q    <= '0;
      line_values_q  <= '0;
      mode_value_q   <= '0;
      field_values_q <= '0;
    end else if (in_acc) begin
      in_line_q      <= in_line_d;
      char_count_q   <= char_count_d;
      token_number_q <= token_number_d;
      token_open_q   <= token_open_d;
      token_length_q <= token_length_d;
      digits_ended_q <= digits_ended_d;
      text_ended_q   <= text_ended_d;
      line_mode_q    <= line_mode_d;
      line_values_q  <= line_values_d;
      mode_value_q   <= mode_value_d;
      field_values_q <= field_values_d;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= new_res;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      if (new_res) begin
        out_q <= result;
      end
    end else if (new_res) begin
      skid_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mode_char_o       = out_q.mode_char;
  assign steam_temp_o      = out_q.values[0];
  assign target_temp_o     = out_q.values[1];
  assign exchanger_temp_o  = out_q.values[2];
  assign boost_countdown_o = out_q.values[3];
  assign heater_on_o       = out_q.values[4];
  assign pump_on_o         = out_q.values[5];

  `TLP_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds item with empty output")
  `TLP_ASSERT(a_idle_clean, !in_line_q |-> char_count_q == '0 && token_number_q == '0, "not idle")
  `TLP_ASSERT(a_count_bound, char_count_q <= LINE_MAX, "line count overran")
  `TLP_ASSERT(a_newline_emits, (in_acc && in_line_q && c == CHAR_NL) |=> out_valid_q, "no result")

endmodule
